### rtl/burst_interval_monitor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the burst interval monitor
// Short forms of the concurrent assertions used by the checker. They expect
// signals named clock and reset in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef BURST_INTERVAL_MONITOR_ASSERT_SVH
`define BURST_INTERVAL_MONITOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define BIM_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("burst interval monitor: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define BIM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("burst interval monitor: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define BIM_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("burst interval monitor: reset check failed");

`endif

### rtl/bim_pkg.sv
// ----------------------------------------------------------------------------
// Burst interval monitor package
// Field widths, codes, reset values and the controller/datapath interface
// types shared by the modules of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bim_pkg;

   localparam int TS_W        = 48;
   localparam int CFG_W       = 32;
   localparam int FC_W        = 8;
   localparam int IVL_W       = 32;
   localparam int OFS_W       = 33;
   localparam int CNT_OUT_W   = 4;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 1;

   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 152;
   localparam int RSP_USER_W  = 2;

   localparam logic [3:0] SUBTYPE_ACTION = 4'hD;

   localparam logic [CFG_W-1:0] EXPECTED_INTERVAL_RESET = 32'd1000000;
   localparam logic [CFG_W-1:0] BURST_TIMEOUT_RESET     = 32'd200000;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_TIMEOUT     = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST_START = 2'd0,
      KIND_INTERVAL    = 2'd1,
      KIND_BURST_END   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELAPSED,
      ST_DECIDE,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PUBLISH
   } bim_state_type;

   typedef struct packed {
      logic load;
      logic calc_elapsed;
      logic end_burst;
      logic first_start;
      logic update;
      logic accumulate;
      logic div_start;
      logic publish;
   } bim_cmd_type;

   typedef struct packed {
      logic is_check;
      logic qualifies;
      logic burst_active;
      logic has_previous;
      logic timeout_hit;
      logic div_busy;
      logic out_free;
   } bim_status_type;

endpackage

`default_nettype wire

### rtl/bim_div.sv
// ----------------------------------------------------------------------------
// Burst interval monitor divider
// Restoring divider that produces one quotient bit per cycle; used to take
// the truncated mean of the stored intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module bim_div #(
   parameter int SUM_W = 36,
   parameter int CNT_W = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  busy,
   output logic [SUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    shifted;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      fits    = shifted >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         busy_in = step_ff != STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/bim_dp.sv
// ----------------------------------------------------------------------------
// Burst interval monitor datapath
// Holds the request, the burst state, the interval ring and its running sum,
// the configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bim_dp #(
   parameter int RING_DEPTH = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bim_pkg::bim_cmd_type             cmd,
   output bim_pkg::bim_status_type               status,
   input  wire logic                             csr_we,
   input  wire logic [bim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bim_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic                             req_opcode,
   input  wire logic                             req_is_management,
   input  wire logic [bim_pkg::FC_W-1:0]         req_frame_control_byte,
   input  wire logic [bim_pkg::TS_W-1:0]         req_timestamp,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_valid,
   output logic [bim_pkg::KIND_W-1:0]            rsp_event_kind,
   output logic [bim_pkg::TS_W-1:0]              rsp_start_time,
   output logic [bim_pkg::IVL_W-1:0]             rsp_interval,
   output logic signed [bim_pkg::OFS_W-1:0]      rsp_instant_offset,
   output logic signed [bim_pkg::OFS_W-1:0]      rsp_average_offset,
   output logic [bim_pkg::CNT_OUT_W-1:0]         rsp_sample_count
);

   import bim_pkg::*;

   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W = IVL_W + CNT_W;

   // Configuration.
   logic [CFG_W-1:0] expected_ff, expected_in;
   logic [CFG_W-1:0] timeout_ff, timeout_in;

   // Request fields.
   logic             opcode_ff, mgmt_ff;
   logic [FC_W-1:0]  fc_ff;
   logic [TS_W-1:0]  now_ff;

   // Burst and ring state.
   logic             active_ff, active_in;
   logic             has_prev_ff, has_prev_in;
   logic [TS_W-1:0]  prev_ff, prev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [TS_W-1:0]  elapsed_ff;
   logic [IVL_W-1:0] ivl_ff;
   logic [IVL_W-1:0] old_ff;
   kind_type         kind_ff;
   logic             ring_full;

   logic [IVL_W-1:0] ring_mem [RING_DEPTH];

   // Mean divider.
   logic             div_busy;
   logic [SUM_W-1:0] quotient;

   // Result register.
   logic                    valid_ff, valid_in;
   logic [KIND_W-1:0]       out_kind_ff;
   logic [TS_W-1:0]         out_start_ff;
   logic [IVL_W-1:0]        out_ivl_ff;
   logic signed [OFS_W-1:0] out_inst_ff, out_avg_ff;
   logic [CNT_OUT_W-1:0]    out_count_ff;
   logic                    is_interval;

   assign ring_full   = count_ff == CNT_W'(RING_DEPTH);
   assign is_interval = kind_ff == KIND_INTERVAL;

   always_comb begin
      expected_in = expected_ff;
      timeout_in  = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_INTERVAL: expected_in = csr_wdata;
            CSR_BURST_TIMEOUT:     timeout_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      active_in   = active_ff;
      has_prev_in = has_prev_ff;
      prev_in     = prev_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      if (cmd.end_burst) begin
         active_in = 1'b0;
      end
      if (cmd.first_start) begin
         active_in   = 1'b1;
         has_prev_in = 1'b1;
         prev_in     = now_ff;
      end
      if (cmd.update) begin
         active_in = 1'b1;
         prev_in   = now_ff;
         if (ring_full) begin
            sum_in = sum_ff - {{CNT_W{1'b0}}, old_ff};
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.accumulate) begin
         sum_in = sum_ff + {{CNT_W{1'b0}}, ivl_ff};
         pos_in = (pos_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   assign valid_in = cmd.publish ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= EXPECTED_INTERVAL_RESET;
         timeout_ff  <= BURST_TIMEOUT_RESET;
         active_ff   <= 1'b0;
         has_prev_ff <= 1'b0;
         prev_ff     <= '0;
         count_ff    <= '0;
         pos_ff      <= '0;
         sum_ff      <= '0;
         valid_ff    <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         timeout_ff  <= timeout_in;
         active_ff   <= active_in;
         has_prev_ff <= has_prev_in;
         prev_ff     <= prev_in;
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         mgmt_ff   <= req_is_management;
         fc_ff     <= req_frame_control_byte;
         now_ff    <= req_timestamp;
      end
      if (cmd.calc_elapsed) begin
         elapsed_ff <= now_ff - prev_ff;
      end
      if (cmd.end_burst) begin
         kind_ff <= KIND_BURST_END;
      end
      if (cmd.first_start) begin
         kind_ff <= KIND_FIRST_START;
      end
      if (cmd.update) begin
         kind_ff <= KIND_INTERVAL;
         ivl_ff  <= (|elapsed_ff[TS_W-1:IVL_W]) ? '1 : elapsed_ff[IVL_W-1:0];
      end
      if (cmd.publish) begin
         out_kind_ff  <= kind_ff;
         out_start_ff <= prev_ff;
         out_ivl_ff   <= is_interval ? ivl_ff : '0;
         out_inst_ff  <= is_interval ? $signed({1'b0, ivl_ff} - {1'b0, expected_ff}) : '0;
         out_avg_ff   <= is_interval ?
                         $signed({1'b0, quotient[IVL_W-1:0]} - {1'b0, expected_ff}) : '0;
         out_count_ff <= CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         ring_mem[pos_ff] <= ivl_ff;
      end
      old_ff <= ring_mem[pos_ff];
   end

   bim_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      status.is_check     = opcode_ff;
      status.qualifies    = mgmt_ff && (fc_ff[FC_W-1:FC_W-4] == SUBTYPE_ACTION);
      status.burst_active = active_ff;
      status.has_previous = has_prev_ff;
      status.timeout_hit  = elapsed_ff >= {{(TS_W - CFG_W){1'b0}}, timeout_ff};
      status.div_busy     = div_busy;
      status.out_free     = !valid_ff || rsp_tready;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = out_kind_ff;
   assign rsp_start_time     = out_start_ff;
   assign rsp_interval       = out_ivl_ff;
   assign rsp_instant_offset = out_inst_ff;
   assign rsp_average_offset = out_avg_ff;
   assign rsp_sample_count   = out_count_ff;

endmodule

`default_nettype wire

### rtl/bim_ctrl.sv
// ----------------------------------------------------------------------------
// Burst interval monitor controller
// Sequences one request at a time through the datapath: elapsed time,
// decision, ring update, mean division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bim_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire bim_pkg::bim_status_type status,
   output bim_pkg::bim_cmd_type         cmd
);

   import bim_pkg::*;

   bim_state_type state_ff, state_in;
   logic          end_now, start_now;

   assign end_now   = status.is_check && status.burst_active && status.timeout_hit;
   assign start_now = !status.is_check && status.qualifies && !status.burst_active;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ELAPSED;
            end
         end
         ST_ELAPSED: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (end_now) begin
               state_in = ST_PUBLISH;
            end else if (start_now) begin
               state_in = status.has_previous ? ST_ACCUM : ST_PUBLISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCUM:     state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_ELAPSED: cmd.calc_elapsed = 1'b1;
         ST_DECIDE: begin
            cmd.end_burst   = end_now;
            cmd.first_start = start_now && !status.has_previous;
            cmd.update      = start_now && status.has_previous;
         end
         ST_ACCUM:     cmd.accumulate = 1'b1;
         ST_DIV_START: cmd.div_start  = 1'b1;
         ST_DIV_WAIT:  ;
         ST_PUBLISH:   cmd.publish    = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/burst_interval_monitor.sv
// ----------------------------------------------------------------------------
// Burst interval monitor
// Detects the start of action-frame bursts in a timestamped event stream and
// reports the interval between starts, the mean of the recent intervals and
// their offsets from the expected interval; time checks end bursts.
//
//   Port group  Direction  Carries
//   req_*       in         one event request (frame or time check)
//   rsp_*       out        one burst start or burst end report
//   csr_*       in         register writes (expected interval, timeout)
//
// A burst start with an interval passes through the elapsed, decide, ring
// accumulate and divide steps before its result; the mean comes from a
// divider that yields one quotient bit per cycle. Other requests skip the
// ring and divider steps. A new request is taken only after the previous
// one is done. Results wait in an output register while rsp_tready is low.
// Reset is synchronous; the interval ring needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module burst_interval_monitor #(
   parameter int RING_DEPTH = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: frame_control_byte [7:0], timestamp [55:8]
   input  wire logic [bim_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: opcode [0], is_management [1]
   input  wire logic [bim_pkg::REQ_USER_W-1:0]   req_tuser,
   // Result channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: start_time [47:0], interval [79:48], instant_offset [112:80],
   // average_offset [145:113], sample_count [149:146], zero [151:150]
   output logic [bim_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // tuser: event_kind [1:0]
   output logic [bim_pkg::RSP_USER_W-1:0]        rsp_tuser,
   // Register write port.
   input  wire logic                             csr_we,
   input  wire logic [bim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bim_pkg::CFG_W-1:0]        csr_wdata
);

   import bim_pkg::*;

   bim_cmd_type             cmd;
   bim_status_type          status;
   logic [KIND_W-1:0]       event_kind;
   logic [TS_W-1:0]         start_time;
   logic [IVL_W-1:0]        interval;
   logic signed [OFS_W-1:0] instant_offset;
   logic signed [OFS_W-1:0] average_offset;
   logic [CNT_OUT_W-1:0]    sample_count;

   bim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bim_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_opcode             (req_tuser[0]),
      .req_is_management      (req_tuser[1]),
      .req_frame_control_byte (req_tdata[FC_W-1:0]),
      .req_timestamp          (req_tdata[FC_W+TS_W-1:FC_W]),
      .rsp_tready             (rsp_tready),
      .rsp_valid              (rsp_tvalid),
      .rsp_event_kind         (event_kind),
      .rsp_start_time         (start_time),
      .rsp_interval           (interval),
      .rsp_instant_offset     (instant_offset),
      .rsp_average_offset     (average_offset),
      .rsp_sample_count       (sample_count)
   );

   assign rsp_tdata = {2'b00, sample_count, average_offset, instant_offset,
                       interval, start_time};
   assign rsp_tuser = event_kind;

endmodule

`default_nettype wire

### rtl/bim_checker.sv
// ----------------------------------------------------------------------------
// Burst interval monitor checker
// Port-level assertions on request pacing, result stability, result fields
// and reset behavior, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "burst_interval_monitor_assert.svh"

module bim_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bim_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [bim_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import bim_pkg::*;

   localparam int IVL_LO = TS_W;
   localparam int AVG_HI = TS_W + IVL_W + 2 * OFS_W - 1;

   `BIM_ASSERT_NEXT(a_one_request_at_a_time, req_tvalid && req_tready, !req_tready)
   `BIM_ASSERT_NEXT(a_result_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `BIM_ASSERT(a_no_interval_without_kind, rsp_tvalid && (rsp_tuser != KIND_INTERVAL), rsp_tdata[AVG_HI:IVL_LO] == '0)
   `BIM_ASSERT_RESET(a_reset_idles, reset, !rsp_tvalid && req_tready)

endmodule

bind burst_interval_monitor bim_checker u_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Burst interval monitor testbench
// Sends frame and time-check requests to the monitor over the request stream
// and predicts each burst start and burst end report from its own model of
// the burst state, the interval ring and the registers. Reports are checked
// field by field in order. A short directed part covers filtering, the exact
// timeout boundary, saturation, timestamp wrap and register extremes. Random
// burst traffic then runs under three register settings, the first two with
// stalls on either side.
// ----------------------------------------------------------------------------
module tb_top;
   import bim_pkg::*;

   localparam int RING_DEPTH = 10;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = 64;
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct {
      kind_type             kind;
      logic [TS_W-1:0]      start_time;
      logic [IVL_W-1:0]     interval;
      logic [OFS_W-1:0]     instant_offset;
      logic [OFS_W-1:0]     average_offset;
      logic [CNT_OUT_W-1:0] sample_count;
   } burst_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   // Predicted register values and burst state.
   logic [CFG_W-1:0]      nominal_interval;
   logic [CFG_W-1:0]      end_timeout;
   logic [IVL_W-1:0]      interval_hist [RING_DEPTH];
   int                    hist_head;
   logic [3:0]            hist_fill;
   logic [35:0]           hist_sum;
   logic                  burst_open;
   logic                  seen_start;
   logic [TS_W-1:0]       last_start;

   burst_report_type      expected_reports [$];
   int                    mismatch_count = 0;
   int                    items_sent = 0;
   int                    cycle_count = 0;
   int                    tx_idle_pct;
   int                    rx_idle_pct;

   burst_interval_monitor #(
      .RING_DEPTH(RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("burst_interval_monitor verification failed");
         $finish;
      end
   end

   function automatic void track_event(input logic op, input logic mgmt,
                                       input logic [FC_W-1:0] fc,
                                       input logic [TS_W-1:0] now_us);
      burst_report_type rpt;
      logic [TS_W-1:0] elapsed;
      logic [35:0] mean;
      elapsed = now_us - last_start;
      rpt.interval = '0;
      rpt.instant_offset = '0;
      rpt.average_offset = '0;
      if (op == OP_CHECK) begin
         if (!burst_open || elapsed < {16'd0, end_timeout}) begin
            return;
         end
         burst_open = 1'b0;
         rpt.kind = KIND_BURST_END;
      end else begin
         if (!mgmt || fc[7:4] != SUBTYPE_ACTION || burst_open) begin
            return;
         end
         burst_open = 1'b1;
         if (!seen_start) begin
            seen_start = 1'b1;
            rpt.kind = KIND_FIRST_START;
         end else begin
            rpt.kind = KIND_INTERVAL;
            rpt.interval = (elapsed > 48'hFFFF_FFFF) ? '1 : elapsed[IVL_W-1:0];
            // Once the ring is full the oldest interval leaves the sum.
            if (hist_fill >= RING_DEPTH) begin
               hist_sum = hist_sum - interval_hist[hist_head];
            end else begin
               hist_fill = hist_fill + 1'b1;
            end
            interval_hist[hist_head] = rpt.interval;
            hist_sum = hist_sum + rpt.interval;
            hist_head = (hist_head + 1) % RING_DEPTH;
            mean = hist_sum / hist_fill;
            rpt.instant_offset = {1'b0, rpt.interval} - {1'b0, nominal_interval};
            rpt.average_offset = {1'b0, mean[IVL_W-1:0]} - {1'b0, nominal_interval};
         end
         last_start = now_us;
      end
      rpt.start_time = last_start;
      rpt.sample_count = hist_fill;
      expected_reports.push_back(rpt);
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_reports
      burst_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: report expected none actual kind %0d", $time, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tuser != want.kind)
               note_mismatch("event_kind", want.kind, rsp_tuser);
            if (rsp_tdata[47:0] != want.start_time)
               note_mismatch("start_time", want.start_time, rsp_tdata[47:0]);
            if (rsp_tdata[79:48] != want.interval)
               note_mismatch("interval", want.interval, rsp_tdata[79:48]);
            if (rsp_tdata[112:80] != want.instant_offset)
               note_mismatch("instant_offset", want.instant_offset, rsp_tdata[112:80]);
            if (rsp_tdata[145:113] != want.average_offset)
               note_mismatch("average_offset", want.average_offset, rsp_tdata[145:113]);
            if (rsp_tdata[149:146] != want.sample_count)
               note_mismatch("sample_count", want.sample_count, rsp_tdata[149:146]);
         end
      end
   end

   task automatic send_event(input logic op, input logic mgmt, input logic [FC_W-1:0] fc,
                             input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ts, fc};
      req_tuser <= {mgmt, op};
      do @(posedge clock); while (!req_tready);
      track_event(op, mgmt, fc, ts);
      items_sent++;
   endtask

   // The extra cycles cover a request that is still in flight without a report.
   task automatic wait_until_quiet();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CFG_W-1:0] nominal,
                                  input logic [CFG_W-1:0] limit);
      csr_we <= 1'b1;
      csr_index <= CSR_EXPECTED_INTERVAL;
      csr_wdata <= nominal;
      @(posedge clock);
      csr_index <= CSR_BURST_TIMEOUT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      nominal_interval = nominal;
      end_timeout = limit;
   endtask

   task automatic test_frame_filtering();
      send_event(OP_FRAME, 1'b0, 8'hD0, 48'd0);
      send_event(OP_FRAME, 1'b1, 8'hC0, 48'd0);
      send_event(OP_FRAME, 1'b1, 8'h2D, 48'd0);
      send_event(OP_CHECK, 1'b1, 8'hD0, 48'd500000);
      send_event(OP_FRAME, 1'b1, 8'hDF, 48'd10);
      send_event(OP_FRAME, 1'b1, 8'hD0, 48'd20);
   endtask

   task automatic test_burst_timeout();
      send_event(OP_CHECK, 1'b0, 8'h00, 48'd200009);
      send_event(OP_CHECK, 1'b0, 8'hFF, 48'd200010);
      send_event(OP_CHECK, 1'b1, 8'h00, 48'd300000);
   endtask

   task automatic test_interval_extremes();
      logic [TS_W-1:0] t;
      send_event(OP_FRAME, 1'b1, 8'hD0, 48'd1000010);
      send_event(OP_CHECK, 1'b0, 8'h00, 48'hFFFF_FFFF_FFFF);
      t = 48'd1000010 + 48'h1_0000_0000;
      send_event(OP_FRAME, 1'b1, 8'hD1, t);
      send_event(OP_CHECK, 1'b0, 8'h00, t + 48'd200000);
      t = t + 48'hFFFF_FFFF;
      send_event(OP_FRAME, 1'b1, 8'hD7, t);
      send_event(OP_CHECK, 1'b0, 8'h00, t + 48'd200000);
      send_event(OP_FRAME, 1'b1, 8'hDE, 48'hFFFF_FFFF_FFF0);
      // Elapsed time across the wrap is exactly the reset timeout.
      send_event(OP_CHECK, 1'b1, 8'hFF, 48'h0000_0003_0D30);
      send_event(OP_FRAME, 1'b1, 8'hD3, 48'd5);
   endtask

   task automatic test_register_extremes();
      wait_until_quiet();
      write_registers('0, '0);
      send_event(OP_CHECK, 1'b0, 8'h00, 48'd5);
      send_event(OP_FRAME, 1'b1, 8'hDD, 48'd5);
      send_event(OP_CHECK, 1'b0, 8'h00, 48'd5);
      wait_until_quiet();
      write_registers('1, '1);
      send_event(OP_FRAME, 1'b1, 8'hD8, 48'd6);
      send_event(OP_CHECK, 1'b0, 8'h00, 48'd6 + 48'hFFFF_FFFE);
      send_event(OP_CHECK, 1'b0, 8'h00, 48'd6 + 48'hFFFF_FFFF);
      send_event(OP_FRAME, 1'b1, 8'hD2, 48'd6 + 48'h100_0000_0000);
   endtask

   // Mostly well-formed bursts: a start, frames inside the burst, an early
   // time check and one at or just past the timeout, then a gap near the
   // nominal interval. Noise requests and missing end checks are mixed in.
   task automatic run_burst_traffic(input int tx_pct, input int rx_pct,
                                    input logic [CFG_W-1:0] nominal,
                                    input logic [CFG_W-1:0] limit, input int quota);
      logic [TS_W-1:0] start_us;
      logic [TS_W-1:0] gap;
      logic [CFG_W-1:0] jitter;
      logic [3:0] subtype;
      int first_item;
      wait_until_quiet();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_registers(nominal, limit);
      start_us = {16'($urandom), 32'($urandom)};
      first_item = items_sent;
      while (items_sent - first_item < quota) begin
         if ($urandom_range(9) == 0) begin
            send_event(1'($urandom), 1'($urandom), 8'($urandom),
                       {16'($urandom), 32'($urandom)});
         end else begin
            send_event(OP_FRAME, 1'b1, {SUBTYPE_ACTION, 4'($urandom)}, start_us);
            repeat ($urandom_range(2)) begin
               subtype = $urandom_range(1) ? SUBTYPE_ACTION : 4'($urandom);
               send_event(OP_FRAME, 1'($urandom), {subtype, 4'($urandom)},
                          start_us + $urandom_range(limit));
            end
            if (limit != 0 && $urandom_range(1))
               send_event(OP_CHECK, 1'($urandom), 8'($urandom),
                          start_us + $urandom_range(limit - 1));
            if ($urandom_range(9) != 0)
               send_event(OP_CHECK, 1'($urandom), 8'($urandom),
                          start_us + limit + $urandom_range(3));
            jitter = nominal / 8 + $urandom_range(63);
            jitter = $urandom_range(jitter);
            if ($urandom_range(19) == 0) begin
               gap = {16'($urandom), 32'($urandom)};
            end else if ($urandom_range(1)) begin
               gap = TS_W'(nominal) + TS_W'(jitter);
            end else if (nominal > jitter) begin
               gap = TS_W'(nominal - jitter);
            end else begin
               gap = TS_W'(jitter);
            end
            start_us = start_us + gap;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      nominal_interval = EXPECTED_INTERVAL_RESET;
      end_timeout = BURST_TIMEOUT_RESET;
      hist_head = 0;
      hist_fill = '0;
      hist_sum = '0;
      burst_open = 1'b0;
      seen_start = 1'b0;
      last_start = '0;
      tx_idle_pct = 32;
      rx_idle_pct = 55;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_frame_filtering();
      test_burst_timeout();
      test_interval_extremes();
      test_register_extremes();
      run_burst_traffic(32, 55, 32'd1000, 32'd250, 590);
      run_burst_traffic(55, 32, '1, '0, 590);
      run_burst_traffic(0, 0, '0, '1, 590);
      wait_until_quiet();
      if (mismatch_count == 0) begin
         $display("burst_interval_monitor verification clean");
      end else begin
         $display("burst_interval_monitor verification failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bim_pkg.sv
rtl/bim_div.sv
rtl/bim_dp.sv
rtl/bim_ctrl.sv
rtl/burst_interval_monitor.sv
rtl/bim_checker.sv
sim/tb_top.sv
